// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the bus-clear sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BCS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define BCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bcs_pkg.sv -----
// Types and constants of the I2C bus-clear sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bcs_pkg;

    localparam int HOLD_W = 8;
    localparam int CNT_W  = 4;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_LOW    = 3'd2,
        PH_HIGH   = 3'd3,
        PH_STOP_A = 3'd4,
        PH_STOP_B = 3'd5,
        PH_STOP_C = 3'd6
    } t_phase;

    // Input beat: cmd = 1 starts recovery, cmd = 0 is one time tick.
    typedef struct packed {
        logic cmd;
        logic sda_level;
    } t_item;

    // Result beat, first field in the highest bits.
    typedef struct packed {
        logic [CNT_W-1:0] pulses_sent;
        logic             done_res;
        logic             busy_res;
        logic             sda_release;
        logic             scl_release;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/bcs_in_stage.sv -----
// Input register of the bus-clear sequencer: holds one accepted beat.
// Depends on bcs_pkg.
`default_nettype none

module bcs_in_stage
    import bcs_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  wire   i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new beat when empty or when the held one moves on this cycle.
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ----- hw/rtl/bcs_fsm.sv -----
// Sequencer state, hold register and next-state logic of the bus-clear block.
// Depends on bcs_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module bcs_fsm
    import bcs_pkg::*;
#(
    parameter int unsigned MAX_PULSES = 9
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    input  wire  [HOLD_W-1:0] i_cfg_data,
    input  wire               i_advance,
    input  t_item             i_item,
    output t_result           o_result
);

    logic [HOLD_W-1:0] r_hold;
    t_phase            r_phase;
    t_phase            n_phase;
    logic [CNT_W-1:0]  r_pulse;
    logic [CNT_W-1:0]  n_pulse;
    logic [HOLD_W-1:0] r_wait;
    logic [HOLD_W-1:0] n_wait;
    logic              r_scl_rel;
    logic              n_scl_rel;
    logic              r_sda_rel;
    logic              n_sda_rel;
    logic              n_done;
    logic [HOLD_W-1:0] hold_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_RESET;
        end else if (i_cfg_valid) begin
            r_hold <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_pulse   <= '0;
            r_wait    <= '0;
            r_scl_rel <= 1'b1;
            r_sda_rel <= 1'b1;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_pulse   <= n_pulse;
            r_wait    <= n_wait;
            r_scl_rel <= n_scl_rel;
            r_sda_rel <= n_sda_rel;
        end
    end

    // A hold of zero behaves as one tick.
    assign hold_load = (r_hold == '0) ? HOLD_RESET : r_hold;

    always_comb begin
        n_phase   = r_phase;
        n_pulse   = r_pulse;
        n_wait    = r_wait;
        n_scl_rel = r_scl_rel;
        n_sda_rel = r_sda_rel;
        n_done    = 1'b0;
        if (r_phase == PH_IDLE) begin
            n_scl_rel = 1'b1;
            n_sda_rel = 1'b1;
            if (i_item.cmd) begin
                n_pulse = '0;
                n_phase = PH_WAIT;
                n_wait  = hold_load;
            end
        end else if (!i_item.cmd) begin
            if (r_wait > HOLD_W'(1)) begin
                n_wait = r_wait - HOLD_W'(1);
            end else begin
                n_wait = hold_load;
                case (r_phase)
                    PH_WAIT, PH_HIGH: begin
                        // Pulse again while a slave still holds SDA low and fewer than MAX_PULSES pulses are sent.
                        if (!i_item.sda_level && (r_pulse < CNT_W'(MAX_PULSES))) begin
                            n_phase   = PH_LOW;
                            n_scl_rel = 1'b0;
                            n_sda_rel = 1'b1;
                        end else begin
                            n_phase   = PH_STOP_A;
                            n_scl_rel = 1'b1;
                            n_sda_rel = 1'b0;
                        end
                    end
                    PH_LOW: begin
                        n_pulse   = r_pulse + CNT_W'(1);
                        n_phase   = PH_HIGH;
                        n_scl_rel = 1'b1;
                        n_sda_rel = 1'b1;
                    end
                    PH_STOP_A: begin
                        n_phase   = PH_STOP_B;
                        n_scl_rel = 1'b1;
                        n_sda_rel = 1'b0;
                    end
                    PH_STOP_B: begin
                        n_phase   = PH_STOP_C;
                        n_scl_rel = 1'b1;
                        n_sda_rel = 1'b1;
                    end
                    default: begin
                        n_phase   = PH_IDLE;
                        n_wait    = '0;
                        n_scl_rel = 1'b1;
                        n_sda_rel = 1'b1;
                        n_done    = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.scl_release = n_scl_rel;
        o_result.sda_release = n_sda_rel;
        o_result.busy_res    = (n_phase != PH_IDLE);
        o_result.done_res    = n_done;
        o_result.pulses_sent = n_pulse;
    end

    `BCS_ASSERT_ALWAYS(a_pulse_limit, i_clk, i_rst_n, r_pulse <= CNT_W'(MAX_PULSES), "pulse count beyond limit")
    `BCS_ASSERT_IMPLY(a_scl_low_phase, i_clk, i_rst_n, !r_scl_rel, r_phase == PH_LOW, "SCL low outside pulse low phase")
    `BCS_ASSERT_IMPLY(a_sda_low_phase, i_clk, i_rst_n, !r_sda_rel, (r_phase == PH_STOP_A) || (r_phase == PH_STOP_B), "SDA low outside STOP")
    `BCS_ASSERT_IMPLY(a_idle_wait, i_clk, i_rst_n, r_phase == PH_IDLE, r_wait == '0, "hold counter running while idle")

endmodule

`default_nettype wire

// ----- hw/rtl/bcs_out_stage.sv -----
// Result register of the bus-clear sequencer: holds one beat until taken.
// Depends on bcs_pkg.
`default_nettype none

module bcs_out_stage
    import bcs_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_load,
    input  t_result i_result,
    output logic    o_can_load,
    output logic    o_valid,
    input  wire     i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/i2c_bus_clear_sequencer.sv -----
// A beat is held in the input register; its result is registered in the result register.
// Throughput: one beat per cycle while the receiver takes results; the state update is one
// pass of next-state logic between the input register and the result register.
// Reset (synchronous, active low): pipeline empty, phase idle, pulse count 0,
// both lines released, hold_ticks = 1.
// Top level of the I2C bus-clear sequencer; depends on bcs_pkg and the bcs_* stages.
`default_nettype none

module i2c_bus_clear_sequencer
    import bcs_pkg::*;
#(
    parameter int unsigned MAX_PULSES = 9
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire  [7:0]       s_axis_tdata,   // [0] sda_level, [7:1] zero
    input  wire              s_axis_tuser,   // [0] cmd
    output logic             m_axis_tvalid,
    input  wire              m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [0] scl_release, [1] sda_release,
                                             // [2] busy_res, [3] done_res, [7:4] pulses_sent
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire  [HOLD_W-1:0] i_cfg_data
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    logic    can_load;
    t_result next_result;
    t_result out_result;

    assign in_item.cmd       = s_axis_tuser;
    assign in_item.sda_level = s_axis_tdata[0];

    // Move the held beat into the result register whenever it has room.
    assign advance     = held_valid && can_load;
    assign o_cfg_ready = 1'b1;

    bcs_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    bcs_fsm #(
        .MAX_PULSES (MAX_PULSES)
    ) u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_advance   (advance),
        .i_item      (held_item),
        .o_result    (next_result)
    );

    bcs_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_result   (next_result),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_result   (out_result)
    );

    assign m_axis_tdata = out_result;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking bench for i2c_bus_clear_sequencer: random ticks and start commands, hold changes.
// Expected status beats come from a line-drive predictor inside the scoreboard class.
// Depends on bcs_pkg and the sequencer RTL only.
`default_nettype none

module tb;
    import bcs_pkg::*;

    localparam int PULSE_LIMIT = 9;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PRINT_CAP   = 20;

    class bus_clear_scoreboard;
        t_phase      phase;
        logic [3:0]  pulse_count;
        logic [7:0]  wait_count;
        logic        scl_rel;
        logic        sda_rel;
        logic [7:0]  hold_ticks;
        t_result     status_due[$];
        int          errors;

        function new();
            phase       = PH_IDLE;
            pulse_count = '0;
            wait_count  = '0;
            scl_rel     = 1'b1;
            sda_rel     = 1'b1;
            hold_ticks  = HOLD_RESET;
            errors      = 0;
        endfunction

        function void enter(t_phase nxt, logic scl, logic sda);
            phase      = nxt;
            scl_rel    = scl;
            sda_rel    = sda;
            // a hold of zero behaves as one tick
            wait_count = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
        endfunction

        function void note_command(logic cmd, logic sda_level);
            t_result exp_beat;
            logic    done;
            done = 1'b0;
            if (phase == PH_IDLE) begin
                scl_rel = 1'b1;
                sda_rel = 1'b1;
                if (cmd) begin
                    pulse_count = '0;
                    enter(PH_WAIT, 1'b1, 1'b1);
                end
            end else if (!cmd) begin
                if (wait_count > 8'd1) begin
                    wait_count = wait_count - 8'd1;
                end else begin
                    wait_count = '0;
                    case (phase)
                        PH_WAIT, PH_HIGH: begin
                            if (!sda_level && pulse_count < PULSE_LIMIT)
                                enter(PH_LOW, 1'b0, 1'b1);
                            else
                                enter(PH_STOP_A, 1'b1, 1'b0);
                        end
                        PH_LOW: begin
                            pulse_count = pulse_count + 4'd1;
                            enter(PH_HIGH, 1'b1, 1'b1);
                        end
                        PH_STOP_A: enter(PH_STOP_B, 1'b1, 1'b0);
                        PH_STOP_B: enter(PH_STOP_C, 1'b1, 1'b1);
                        default: begin
                            phase      = PH_IDLE;
                            wait_count = '0;
                            scl_rel    = 1'b1;
                            sda_rel    = 1'b1;
                            done       = 1'b1;
                        end
                    endcase
                end
            end
            exp_beat.scl_release = scl_rel;
            exp_beat.sda_release = sda_rel;
            exp_beat.busy_res    = (phase != PH_IDLE);
            exp_beat.done_res    = done;
            exp_beat.pulses_sent = pulse_count;
            status_due.push_back(exp_beat);
        endfunction

        function void check_status(t_result got);
            t_result want;
            if (status_due.size() == 0) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: status beat with none expected: actual %h", $time, got);
                return;
            end
            want = status_due.pop_front();
            if (got.scl_release !== want.scl_release) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: scl_release expected %b actual %b",
                             $time, want.scl_release, got.scl_release);
            end
            if (got.sda_release !== want.sda_release) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: sda_release expected %b actual %b",
                             $time, want.sda_release, got.sda_release);
            end
            if (got.busy_res !== want.busy_res) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: busy_res expected %b actual %b",
                             $time, want.busy_res, got.busy_res);
            end
            if (got.done_res !== want.done_res) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: done_res expected %b actual %b",
                             $time, want.done_res, got.done_res);
            end
            if (got.pulses_sent !== want.pulses_sent) begin
                errors++;
                if (errors <= PRINT_CAP)
                    $display("%0t: pulses_sent expected %0d actual %0d",
                             $time, want.pulses_sent, got.pulses_sent);
            end
        endfunction
    endclass

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [7:0]        m_axis_tdata;
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic [HOLD_W-1:0] i_cfg_data    = '0;

    bus_clear_scoreboard sb;
    bit          tx_burst = 1'b0;
    bit          rx_burst = 1'b0;
    int unsigned rx_stall = 0;
    int unsigned rx_roll;
    int          cycles = 0;
    int          phase_ticks;
    logic [7:0]  hold_plan [7];

    i2c_bus_clear_sequencer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** i2c_bus_clear_sequencer: FAILED **");
            $finish;
        end
    end

    // receiver: stall at random, mostly short
    always @(negedge i_clk) begin
        if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= rx_stall - 1;
        end else begin
            m_axis_tready <= 1'b1;
            if (!rx_burst) begin
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 20)
                    rx_stall <= $urandom_range(1, 3);
                else if (rx_roll < 23)
                    rx_stall <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_status(t_result'(m_axis_tdata));
    end

    // returns at the edge that took the beat; the prediction is updated there
    task automatic send_item(logic cmd, logic sda_level);
        int unsigned roll;
        int unsigned gap;
        gap = 0;
        if (!tx_burst) begin
            roll = $urandom_range(0, 99);
            if (roll >= 90)
                gap = $urandom_range(8, 40);
            else if (roll >= 60)
                gap = $urandom_range(1, 3);
        end
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {7'd0, sda_level};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_command(cmd, sda_level);
    endtask

    // hold off the sender until every expected beat is back
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.status_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_hold(logic [7:0] value);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.hold_ticks = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one start followed by ticks until the sequence ends; SDA frees up after
    // release_after pulses, noise adds idle ticks, ignored starts and SDA flips
    task automatic run_recovery(int unsigned release_after, bit noisy);
        logic cmd;
        logic sda;
        if (noisy && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_item(1'b0, 1'($urandom_range(0, 1)));
        end
        send_item(1'b1, 1'($urandom_range(0, 1)));
        phase_ticks++;
        while (sb.phase != PH_IDLE) begin
            cmd = 1'b0;
            sda = (sb.pulse_count >= release_after);
            if (noisy) begin
                if ($urandom_range(0, 19) == 0)
                    cmd = 1'b1;
                if ($urandom_range(0, 9) == 0)
                    sda = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
            send_item(cmd, sda);
            phase_ticks++;
        end
    endtask

    initial begin
        sb = new();
        hold_plan = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd60, 8'd0, 8'd1};
        hold_plan[5] = 8'($urandom_range(4, 9));
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset hold: idle ticks, start, ignored start, full nine-pulse run
        send_item(1'b0, 1'b0);
        send_item(1'b0, 1'b1);
        send_item(1'b1, 1'b0);
        send_item(1'b1, 1'b1);
        while (sb.phase != PH_IDLE) send_item(1'b0, 1'b0);

        foreach (hold_plan[k]) begin
            write_hold(hold_plan[k]);
            tx_burst = ($urandom_range(0, 2) == 0);
            rx_burst = ($urandom_range(0, 2) == 0);
            phase_ticks = 0;
            if (hold_plan[k] == 8'd60) begin
                run_recovery(0, 1'b0);
            end else begin
                while (phase_ticks < 80)
                    run_recovery($urandom_range(0, 11), 1'b1);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.status_due.size() == 0) begin
            $display("** i2c_bus_clear_sequencer: PASSED **");
        end else begin
            $display("** i2c_bus_clear_sequencer: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
